FILE: hdl/nonpreemptive_sjf_scheduler_unit_macros.svh
// Assertion macros for the shortest-job-first scheduler.
// Included by the top level; no other dependencies.
`ifndef NONPREEMPTIVE_SJF_SCHEDULER_UNIT_MACROS_SVH
`define NONPREEMPTIVE_SJF_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define SJF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sjf scheduler: same-cycle check failed");

// Next-cycle implication under synchronous active-low reset.
`define SJF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sjf scheduler: next-cycle check failed");

`endif

FILE: hdl/sjf_pkg.sv
// Shared types and constants of the shortest-job-first scheduler.
// Used by sjf_ctrl, sjf_datapath and the top level; no dependencies.
package sjf_pkg;

  localparam int MAX_JOBS_DEF = 16;

  localparam int ID_W   = 4;
  localparam int TIME_W = 16;
  localparam int BUR_W  = 16;
  localparam int CT_W   = 21;

  localparam int IN_DATA_W  = 40;  // 36 bits of fields, zero-filled to bytes
  localparam int OUT_DATA_W = 48;  // 41 bits of fields, zero-filled to bytes

  localparam logic [CT_W-1:0] CT_MAX = CT_W'(1114095);

  // Controller to datapath
  typedef struct packed {
    logic load;        // input item accepted: store it
    logic start;       // last item accepted: start the clock
    logic scan_start;  // rewind scan address, clear selection
    logic scan_step;   // read one table entry
    logic pick;        // commit the selection to the output register
  } sjf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;   // address being read is the last loaded entry
    logic out_free;   // output register can take a result this cycle
    logic pick_last;  // the pending pick is the final one of the batch
  } sjf_status_t;

endpackage

FILE: hdl/sjf_ctrl.sv
// Sequencer of the scheduler: load, scan, drain, pick.
// Depends on sjf_pkg.
module sjf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  input  sjf_pkg::sjf_status_t st,
  output sjf_pkg::sjf_cmd_t    cmd
);
  import sjf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_PICK  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && in_tlast) begin
          cmd.start      = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data folds into the selection here
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (st.out_free) begin
          cmd.pick = 1'b1;
          if (st.pick_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/sjf_datapath.sv
// Job table, scan accumulators, clock and output register of the scheduler.
// Depends on sjf_pkg; driven by sjf_ctrl.
module sjf_datapath #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sjf_pkg::sjf_cmd_t             cmd,
  output sjf_pkg::sjf_status_t          st,
  input  logic [sjf_pkg::ID_W-1:0]      job_id,
  input  logic [sjf_pkg::TIME_W-1:0]    arrival_time,
  input  logic [sjf_pkg::BUR_W-1:0]     burst_length,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [sjf_pkg::ID_W-1:0]      sched_id,
  output logic [sjf_pkg::BUR_W-1:0]     sched_burst,
  output logic [sjf_pkg::CT_W-1:0]      completion_time,
  output logic                          last_result
);
  import sjf_pkg::*;

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int ENT_W = ID_W + TIME_W + BUR_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // entry layout: {id, arrival, burst}
  logic [ENT_W-1:0] table_mem [MAX_JOBS];
  logic [ENT_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic [CNT_W-1:0]  job_count_r, pick_cnt_r, scan_addr_r;
  logic [MAX_JOBS-1:0] done_r;
  logic [TIME_W-1:0] first_arr_r;
  logic [CT_W-1:0]   cur_time_r;

  // shortest arrived job
  logic              best_found_r;
  logic [BUR_W-1:0]  best_bur_r;
  logic [ID_W-1:0]   best_id_r;
  logic [IDX_W-1:0]  best_idx_r;
  // fallback: earliest pending arrival, shortest among those
  logic              min_found_r;
  logic [TIME_W-1:0] min_arr_r;
  logic [BUR_W-1:0]  min_bur_r;
  logic [ID_W-1:0]   min_id_r;
  logic [IDX_W-1:0]  min_idx_r;

  logic [ID_W-1:0]   e_id;
  logic [TIME_W-1:0] e_arr;
  logic [BUR_W-1:0]  e_bur;
  logic              e_pending, take_best, take_min;
  logic              can_store;

  logic [CT_W-1:0]   base_time;
  logic [BUR_W-1:0]  sel_bur;
  logic [ID_W-1:0]   sel_id;
  logic [IDX_W-1:0]  sel_idx;
  logic [CT_W:0]     sum;
  logic [CT_W-1:0]   comp;

  assign can_store = (job_count_r < CNT_MAX);

  assign {e_id, e_arr, e_bur} = rd_data_r;
  assign e_pending = rd_vld_r && !done_r[rd_idx_r];
  assign take_best = e_pending && ({{(CT_W-TIME_W){1'b0}}, e_arr} <= cur_time_r) &&
                     (!best_found_r || (e_bur <= best_bur_r));
  assign take_min  = e_pending && (!min_found_r || (e_arr < min_arr_r) ||
                     ((e_arr == min_arr_r) && (e_bur <= min_bur_r)));

  // With nothing arrived, jump the clock to the earliest pending arrival.
  assign base_time = best_found_r ? cur_time_r : {{(CT_W-TIME_W){1'b0}}, min_arr_r};
  assign sel_bur   = best_found_r ? best_bur_r : min_bur_r;
  assign sel_id    = best_found_r ? best_id_r  : min_id_r;
  assign sel_idx   = best_found_r ? best_idx_r : min_idx_r;
  assign sum       = {1'b0, base_time} + {{(CT_W+1-BUR_W){1'b0}}, sel_bur};
  assign comp      = (sum > {1'b0, CT_MAX}) ? CT_MAX : sum[CT_W-1:0];

  assign st.scan_end  = ((scan_addr_r + CNT_ONE) == job_count_r);
  assign st.out_free  = !out_tvalid || out_tready;
  assign st.pick_last = ((pick_cnt_r + CNT_ONE) == job_count_r);

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && can_store) begin
      table_mem[job_count_r[IDX_W-1:0]] <= {job_id, arrival_time, burst_length};
    end
    if (cmd.scan_step) begin
      rd_data_r <= table_mem[scan_addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r  <= '0;
      pick_cnt_r   <= '0;
      done_r       <= '0;
      cur_time_r   <= '0;
      scan_addr_r  <= '0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      min_found_r  <= 1'b0;
      out_tvalid   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step;

      if (cmd.load && can_store) begin
        job_count_r <= job_count_r + CNT_ONE;
      end
      if (cmd.start) begin
        cur_time_r <= {{(CT_W-TIME_W){1'b0}},
                       (job_count_r == '0) ? arrival_time : first_arr_r};
      end

      if (cmd.scan_start) begin
        scan_addr_r  <= '0;
        best_found_r <= 1'b0;
        min_found_r  <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_addr_r <= scan_addr_r + CNT_ONE;
        end
        if (take_best) begin
          best_found_r <= 1'b1;
        end
        if (take_min) begin
          min_found_r <= 1'b1;
        end
      end

      if (cmd.pick) begin
        out_tvalid <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
      if (cmd.pick) begin
        cur_time_r <= comp;
        if (st.pick_last) begin
          // close the batch: drop the table, keep the clock
          job_count_r <= '0;
          pick_cnt_r  <= '0;
          done_r      <= '0;
        end else begin
          pick_cnt_r       <= pick_cnt_r + CNT_ONE;
          done_r[sel_idx]  <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load && can_store && (job_count_r == '0)) begin
      first_arr_r <= arrival_time;
    end
    if (cmd.scan_step) begin
      rd_idx_r <= scan_addr_r[IDX_W-1:0];
    end
    if (take_best) begin
      best_bur_r <= e_bur;
      best_id_r  <= e_id;
      best_idx_r <= rd_idx_r;
    end
    if (take_min) begin
      min_arr_r <= e_arr;
      min_bur_r <= e_bur;
      min_id_r  <= e_id;
      min_idx_r <= rd_idx_r;
    end
    if (cmd.pick) begin
      sched_id        <= sel_id;
      sched_burst     <= sel_bur;
      completion_time <= comp;
      last_result     <= st.pick_last;
    end
  end

endmodule

FILE: hdl/nonpreemptive_sjf_scheduler_unit.sv
// Non-preemptive shortest-job-first scheduler: loads a batch of jobs
// (id, arrival, burst; the item with in_tlast closes the batch) into a
// MAX_JOBS-entry table at one item per cycle, then emits the schedule: at
// each step the shortest arrived unfinished job runs (ties go to the
// later-loaded job), or, if none has arrived, the clock jumps to the earliest
// pending arrival first. Each result carries the job id, its burst and its
// completion time, saturating at 1114095; out_tlast marks the final result.
// The clock starts at the first loaded job's arrival. Jobs beyond MAX_JOBS
// are dropped. Each result needs a scan that reads every loaded entry through
// the single read port, a step that folds the last read into the selection,
// and a commit once the output register has room; no new input is taken
// until the last result of the batch is in the output register. Depends on
// sjf_pkg, sjf_ctrl, sjf_datapath and the macro header.
`include "nonpreemptive_sjf_scheduler_unit_macros.svh"

module nonpreemptive_sjf_scheduler_unit #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, low bit up: job_id[3:0], arrival_time[19:4], burst_length[35:20], zero
  input  logic [sjf_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,   // last_job
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata, low bit up: sched_id[3:0], sched_burst[19:4], completion_time[40:20], zero
  output logic [sjf_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,  // last_result
  output logic                             out_tvalid,
  input  logic                             out_tready
);
  import sjf_pkg::*;

  localparam int IN_USED  = ID_W + TIME_W + BUR_W;
  localparam int OUT_USED = ID_W + BUR_W + CT_W;

  sjf_cmd_t    cmd;
  sjf_status_t st;

  logic [ID_W-1:0]   sched_id;
  logic [BUR_W-1:0]  sched_burst;
  logic [CT_W-1:0]   completion_time;

  sjf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sjf_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .job_id          (in_tdata[ID_W-1:0]),
    .arrival_time    (in_tdata[ID_W+TIME_W-1:ID_W]),
    .burst_length    (in_tdata[IN_USED-1:ID_W+TIME_W]),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .sched_id        (sched_id),
    .sched_burst     (sched_burst),
    .completion_time (completion_time),
    .last_result     (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W-OUT_USED){1'b0}}, completion_time, sched_burst, sched_id};

  // A result is only committed when the output register has room.
  `SJF_ASSERT_NOW(a_pick_room, clk, rst_n, cmd.pick, st.out_free)
  // The closing item of a batch stops intake until the schedule is out.
  `SJF_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready)
  // Committing the final pick returns the block to loading.
  `SJF_ASSERT_NEXT(a_idle_after_final, clk, rst_n, cmd.pick && st.pick_last,
                   in_tready && out_tvalid && out_tlast)

endmodule
